// ===== rtl/pgr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page replacement tracker package
// Shared widths, reset values, register and policy codes, the sequencer
// state type and the result record of the page replacement tracker.
// ----------------------------------------------------------------------------
package pgr_pkg;

    // Default sizing of the page table.
    localparam int MAX_PROCS_DEF      = 8;
    localparam int PAGES_PER_PROC_DEF = 64;

    // Fixed field widths.
    localparam int PID_W      = 3;
    localparam int PAGE_W     = 16;
    localparam int CNT_W      = 24;
    localparam int QUOTA_W    = 10;
    localparam int FRAMES_W   = 10;
    localparam int PERIOD_W   = 16;
    localparam int PCOUNT_W   = 4;
    localparam int NPROC_W    = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};
    localparam logic [QUOTA_W-1:0] QUOTA_MAX = {QUOTA_W{1'b1}};

    // Register values after reset.
    localparam logic [PCOUNT_W-1:0] PCOUNT_RST = 4'd1;
    localparam logic [FRAMES_W-1:0] FRAMES_RST = 10'd16;
    localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd100;

    // Replacement policies.
    typedef enum logic [1:0] {
        POL_FIFO   = 2'd0,
        POL_SECOND = 2'd1,
        POL_LRU    = 2'd2,
        POL_LFU    = 2'd3
    } policy_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POLICY = 3'd0,
        REG_LOCAL  = 3'd1,
        REG_PCOUNT = 3'd2,
        REG_FRAMES = 3'd3,
        REG_PERIOD = 3'd4
    } cfg_reg_t;

    // Sequencer states.
    typedef enum logic [4:0] {
        S_CLR,
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_EV,
        S_FAULT,
        S_LV_RD,
        S_LV_EV,
        S_QRD,
        S_QE,
        S_QEV,
        S_QEND,
        S_EVICT,
        S_EVICT2,
        S_LOAD,
        S_FIN,
        S_DONE,
        S_RCLR
    } state_t;

    // One result item.
    typedef struct packed {
        logic              hit;
        logic              fault;
        logic              ev_valid;
        logic [PID_W-1:0]  ev_proc;
        logic [PAGE_W-1:0] ev_page;
        logic              table_full;
        logic [CNT_W-1:0]  faults;
    } result_t;

endpackage

// ===== rtl/pgr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page replacement tracker RAM
// Simple memory with one write port and one read port; read data is
// registered.
// ----------------------------------------------------------------------------
module pgr_ram #(
    parameter int W  = 1,
    parameter int D  = 2,
    parameter int AW = 1
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [W-1:0]  wdata,
    input  logic [AW-1:0] raddr,
    output logic [W-1:0]  rdata
);

    logic [W-1:0] mem [D];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/pgr_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page replacement tracker divider
// Restoring divider, one quotient bit per cycle, used to share the frames
// equally among the active processes.
// ----------------------------------------------------------------------------
module pgr_div #(
    parameter int DW = 10,
    parameter int VW = 5
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          busy,
    output logic [DW-1:0] quotient,
    output logic [VW-1:0] remainder
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] quo_reg, quo_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [VW:0]   trial;

    // One subtract and compare step per cycle.
    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        trial    = {rem_reg, quo_reg[DW-1]};
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            cnt_next = CW'(DW);
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (trial >= {1'b0, divisor})
            begin
                rem_next = VW'(trial - {1'b0, divisor});
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = VW'(trial);
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg <= '0;
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
            cnt_reg <= cnt_next;
        end
    end

    assign busy      = (cnt_reg != '0);
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/page_replacement_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page replacement tracker
// Tracks page mappings per process, reports hits and faults and chooses a
// victim by FIFO, second chance, LRU or LFU, locally or globally.
// ----------------------------------------------------------------------------
// Each access is handled by a sequencer over entry memories with one read
// port each, so one memory read per cycle sets the pace. An access searches
// the mapped pages of its process in order. A fault at quota adds a victim
// scan over the load-order queue (up to MAX_PROCS x PAGES_PER_PROC entries),
// or over the mapped pages for local LRU and LFU, then eviction and loading.
// Every ref_clear_period accesses, all reference bits are cleared before the
// next access is taken. After reset and after a write to process_count or
// total_frames the block clears its tables, one entry per cycle; configuration
// writes are taken at any time. One result is held in an output register, so
// a new access is taken while the previous result still waits.
// ----------------------------------------------------------------------------
module page_replacement_tracker #(
    parameter int MAX_PROCS      = pgr_pkg::MAX_PROCS_DEF,
    parameter int PAGES_PER_PROC = pgr_pkg::PAGES_PER_PROC_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pgr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pgr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [pgr_pkg::PID_W-1:0]       process_id,
    input  logic [pgr_pkg::PAGE_W-1:0]      page_address,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            hit,
    output logic                            fault,
    output logic                            evicted_valid,
    output logic [pgr_pkg::PID_W-1:0]       evicted_process,
    output logic [pgr_pkg::PAGE_W-1:0]      evicted_page,
    output logic                            table_full,
    output logic [pgr_pkg::CNT_W-1:0]       process_faults
);

    import pgr_pkg::*;

    localparam int NE = MAX_PROCS * PAGES_PER_PROC;
    localparam int EW = (NE > 1) ? $clog2(NE) : 1;
    localparam int QW = $clog2(NE + 1);
    localparam int PW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int MW = $clog2(PAGES_PER_PROC + 1);
    localparam int LW = (MW > QUOTA_W) ? MW : QUOTA_W;

    // Configuration registers.
    policy_t             policy_reg, policy_next;
    logic                local_reg, local_next;
    logic [PCOUNT_W-1:0] pcount_reg, pcount_next;
    logic [FRAMES_W-1:0] frames_reg, frames_next;
    logic [PERIOD_W-1:0] period_reg, period_next;

    // Sequencer registers.
    state_t              state_reg, state_next;
    logic [PW-1:0]       p_reg, p_next;
    logic [PAGE_W-1:0]   addr_reg, addr_next;
    logic [QW-1:0]       idx_reg, idx_next;
    logic                found_reg, found_next;
    logic [EW-1:0]       e_reg, e_next;
    logic [EW-1:0]       qe_reg, qe_next;
    logic                cand_reg, cand_next;
    logic [EW-1:0]       victim_reg, victim_next;
    logic [CNT_W-1:0]    best_reg, best_next;
    logic                fseen_reg, fseen_next;
    logic [EW-1:0]       first_reg, first_next;
    logic                sweep_reg, sweep_next;
    logic [QW-1:0]       qlen_reg, qlen_next;
    logic [CNT_W-1:0]    time_reg, time_next;
    logic [PERIOD_W-1:0] ccount_reg, ccount_next;
    logic                div_go_reg, div_go_next;
    logic                out_valid_reg, out_valid_next;
    result_t             res_reg, res_next;
    result_t             out_reg, out_next;

    // Per-process bookkeeping.
    logic [MW-1:0]      mapped_reg [MAX_PROCS];
    logic [MW-1:0]      mapped_next [MAX_PROCS];
    logic [LW-1:0]      loaded_reg [MAX_PROCS];
    logic [LW-1:0]      loaded_next [MAX_PROCS];
    logic [QUOTA_W-1:0] quota_reg [MAX_PROCS];
    logic [QUOTA_W-1:0] quota_next [MAX_PROCS];
    logic [CNT_W-1:0]   faults_reg [MAX_PROCS];
    logic [CNT_W-1:0]   faults_next [MAX_PROCS];

    // Memory ports.
    logic [EW-1:0]     ent_raddr, q_raddr;
    logic              pg_we, ow_we, pr_we, rf_we, lu_we, uc_we, qu_we;
    logic [EW-1:0]     pg_wa, ow_wa, pr_wa, rf_wa, lu_wa, uc_wa, qu_wa;
    logic [PAGE_W-1:0] pg_wd, pg_rd;
    logic [PW-1:0]     ow_wd, ow_rd;
    logic              pr_wd, pr_rd, rf_wd, rf_rd;
    logic [CNT_W-1:0]  lu_wd, lu_rd, uc_wd, uc_rd;
    logic [EW-1:0]     qu_wd, qu_rd;

    // Divider for the equal frame share.
    logic                div_busy;
    logic [FRAMES_W-1:0] share;
    logic [NPROC_W-1:0]  share_rem;

    // Helpers.
    logic [NPROC_W-1:0] nact;
    logic [EW-1:0]      base_e;
    logic [CNT_W-1:0]   key;
    logic               elig;
    logic [PERIOD_W:0]  ccount_inc;

    // Effective process count.
    always_comb
    begin
        if (pcount_reg == '0)
        begin
            nact = NPROC_W'(1);
        end
        else if (NPROC_W'(pcount_reg) > NPROC_W'(MAX_PROCS))
        begin
            nact = NPROC_W'(MAX_PROCS);
        end
        else
        begin
            nact = NPROC_W'(pcount_reg);
        end
    end

    assign base_e     = EW'(EW'(p_reg) * EW'(PAGES_PER_PROC));
    assign key        = (policy_reg == POL_LRU) ? lu_rd : uc_rd;
    assign elig       = pr_rd && (!local_reg || (ow_rd == p_reg));
    assign ccount_inc = {1'b0, ccount_reg} + 1'b1;

    pgr_div #(
        .DW (FRAMES_W),
        .VW (NPROC_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_go_reg),
        .dividend  (frames_reg),
        .divisor   (nact),
        .busy      (div_busy),
        .quotient  (share),
        .remainder (share_rem)
    );

    // Entry memories, all read at one address.
    pgr_ram #(.W(PAGE_W), .D(NE), .AW(EW)) u_page (
        .clk(clk), .we(pg_we), .waddr(pg_wa), .wdata(pg_wd),
        .raddr(ent_raddr), .rdata(pg_rd));
    pgr_ram #(.W(PW), .D(NE), .AW(EW)) u_owner (
        .clk(clk), .we(ow_we), .waddr(ow_wa), .wdata(ow_wd),
        .raddr(ent_raddr), .rdata(ow_rd));
    pgr_ram #(.W(1), .D(NE), .AW(EW)) u_present (
        .clk(clk), .we(pr_we), .waddr(pr_wa), .wdata(pr_wd),
        .raddr(ent_raddr), .rdata(pr_rd));
    pgr_ram #(.W(1), .D(NE), .AW(EW)) u_refbit (
        .clk(clk), .we(rf_we), .waddr(rf_wa), .wdata(rf_wd),
        .raddr(ent_raddr), .rdata(rf_rd));
    pgr_ram #(.W(CNT_W), .D(NE), .AW(EW)) u_last_use (
        .clk(clk), .we(lu_we), .waddr(lu_wa), .wdata(lu_wd),
        .raddr(ent_raddr), .rdata(lu_rd));
    pgr_ram #(.W(CNT_W), .D(NE), .AW(EW)) u_use_cnt (
        .clk(clk), .we(uc_we), .waddr(uc_wa), .wdata(uc_wd),
        .raddr(ent_raddr), .rdata(uc_rd));

    // Load-order queue of entry indexes.
    pgr_ram #(.W(EW), .D(NE), .AW(EW)) u_queue (
        .clk(clk), .we(qu_we), .waddr(qu_wa), .wdata(qu_wd),
        .raddr(q_raddr), .rdata(qu_rd));

    // Sequencer: next state, bookkeeping and memory writes.
    always_comb
    begin
        state_next     = state_reg;
        policy_next    = policy_reg;
        local_next     = local_reg;
        pcount_next    = pcount_reg;
        frames_next    = frames_reg;
        period_next    = period_reg;
        p_next         = p_reg;
        addr_next      = addr_reg;
        idx_next       = idx_reg;
        found_next     = found_reg;
        e_next         = e_reg;
        qe_next        = qe_reg;
        cand_next      = cand_reg;
        victim_next    = victim_reg;
        best_next      = best_reg;
        fseen_next     = fseen_reg;
        first_next     = first_reg;
        sweep_next     = sweep_reg;
        qlen_next      = qlen_reg;
        time_next      = time_reg;
        ccount_next    = ccount_reg;
        div_go_next    = 1'b0;
        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        mapped_next    = mapped_reg;
        loaded_next    = loaded_reg;
        quota_next     = quota_reg;
        faults_next    = faults_reg;

        ent_raddr = base_e + EW'(idx_reg);
        q_raddr   = EW'(idx_reg);
        pg_we = 1'b0; pg_wa = e_reg; pg_wd = addr_reg;
        ow_we = 1'b0; ow_wa = e_reg; ow_wd = p_reg;
        pr_we = 1'b0; pr_wa = e_reg; pr_wd = 1'b0;
        rf_we = 1'b0; rf_wa = e_reg; rf_wd = 1'b0;
        lu_we = 1'b0; lu_wa = e_reg; lu_wd = time_reg;
        uc_we = 1'b0; uc_wa = e_reg; uc_wd = '0;
        qu_we = 1'b0; qu_wa = EW'(qlen_reg); qu_wd = e_reg;

        // The waiting result leaves on its transfer.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            // Table clear after reset or a sizing change.
            S_CLR:
            begin
                for (int i = 0; i < MAX_PROCS; i++)
                begin
                    mapped_next[i] = '0;
                    loaded_next[i] = '0;
                    faults_next[i] = '0;
                end
                qlen_next   = '0;
                time_next   = '0;
                ccount_next = '0;
                sweep_next  = 1'b0;
                pr_wa = EW'(idx_reg);
                rf_wa = EW'(idx_reg);
                if (idx_reg != QW'(NE))
                begin
                    pr_we    = 1'b1;
                    rf_we    = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
                else if (!div_busy && !div_go_reg)
                begin
                    for (int i = 0; i < MAX_PROCS; i++)
                    begin
                        if (NPROC_W'(i + 1) < nact)
                        begin
                            quota_next[i] = share;
                        end
                        else if (NPROC_W'(i + 1) == nact)
                        begin
                            quota_next[i] = share + QUOTA_W'(share_rem);
                        end
                        else
                        begin
                            quota_next[i] = '0;
                        end
                    end
                    state_next = S_IDLE;
                end
            end

            // Take an access; inactive processes give an empty result.
            S_IDLE:
            begin
                if (in_valid)
                begin
                    p_next     = PW'(process_id);
                    addr_next  = page_address;
                    idx_next   = '0;
                    found_next = 1'b0;
                    res_next   = '0;
                    if (NPROC_W'(process_id) >= nact)
                    begin
                        sweep_next = 1'b0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SRCH_RD;
                    end
                end
            end

            // Search the process's mapped slots in order.
            S_SRCH_RD:
            begin
                if (idx_reg < QW'(mapped_reg[p_reg]))
                begin
                    state_next = S_SRCH_EV;
                end
                else
                begin
                    state_next = S_FAULT;
                end
            end

            S_SRCH_EV:
            begin
                if (pg_rd == addr_reg)
                begin
                    found_next = 1'b1;
                    e_next     = ent_raddr;
                    if (pr_rd)
                    begin
                        rf_we = 1'b1; rf_wa = ent_raddr; rf_wd = 1'b1;
                        lu_we = 1'b1; lu_wa = ent_raddr;
                        uc_we = 1'b1; uc_wa = ent_raddr;
                        uc_wd = (uc_rd != CNT_MAX) ? uc_rd + 1'b1 : uc_rd;
                        res_next.hit = 1'b1;
                        state_next   = S_FIN;
                    end
                    else
                    begin
                        state_next = S_FAULT;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SRCH_RD;
                end
            end

            // Count the fault and decide whether a victim is needed.
            S_FAULT:
            begin
                res_next.fault = 1'b1;
                if (faults_reg[p_reg] != CNT_MAX)
                begin
                    faults_next[p_reg] = faults_reg[p_reg] + 1'b1;
                end
                idx_next   = '0;
                cand_next  = 1'b0;
                fseen_next = 1'b0;
                best_next  = '0;
                if (!found_reg && (mapped_reg[p_reg] >= MW'(PAGES_PER_PROC)))
                begin
                    res_next.table_full = 1'b1;
                    state_next          = S_FIN;
                end
                else if (loaded_reg[p_reg] >= LW'(quota_reg[p_reg]))
                begin
                    if (local_reg && ((policy_reg == POL_LRU) || (policy_reg == POL_LFU)))
                    begin
                        state_next = S_LV_RD;
                    end
                    else
                    begin
                        state_next = S_QRD;
                    end
                end
                else
                begin
                    state_next = S_LOAD;
                end
            end

            // Local LRU or LFU: first minimum over the process's slots.
            S_LV_RD:
            begin
                if (idx_reg < QW'(mapped_reg[p_reg]))
                begin
                    state_next = S_LV_EV;
                end
                else
                begin
                    state_next = cand_reg ? S_EVICT : S_FIN;
                end
            end

            S_LV_EV:
            begin
                if (pr_rd && (!cand_reg || (key < best_reg)))
                begin
                    cand_next   = 1'b1;
                    best_next   = key;
                    victim_next = ent_raddr;
                end
                idx_next   = idx_reg + 1'b1;
                state_next = S_LV_RD;
            end

            // Queue scan: fetch the queued entry index.
            S_QRD:
            begin
                if (idx_reg < qlen_reg)
                begin
                    state_next = S_QE;
                end
                else
                begin
                    state_next = S_QEND;
                end
            end

            S_QE:
            begin
                ent_raddr  = qu_rd;
                qe_next    = qu_rd;
                state_next = S_QEV;
            end

            // Judge one queued entry under the selected policy.
            S_QEV:
            begin
                ent_raddr  = qe_reg;
                idx_next   = idx_reg + 1'b1;
                state_next = S_QRD;
                case (policy_reg)
                    POL_FIFO:
                    begin
                        if (elig)
                        begin
                            victim_next = qe_reg;
                            cand_next   = 1'b1;
                            state_next  = S_EVICT;
                        end
                    end
                    POL_SECOND:
                    begin
                        if (elig)
                        begin
                            if (!fseen_reg)
                            begin
                                fseen_next = 1'b1;
                                first_next = qe_reg;
                            end
                            if (!rf_rd)
                            begin
                                victim_next = qe_reg;
                                cand_next   = 1'b1;
                                state_next  = S_EVICT;
                            end
                            else
                            begin
                                rf_we = 1'b1;
                                rf_wa = qe_reg;
                                rf_wd = 1'b0;
                            end
                        end
                    end
                    default:
                    begin
                        if (elig && (!cand_reg || (key <= best_reg)))
                        begin
                            cand_next   = 1'b1;
                            best_next   = key;
                            victim_next = qe_reg;
                        end
                    end
                endcase
            end

            // End of queue: second chance falls back to the first eligible.
            S_QEND:
            begin
                if (policy_reg == POL_SECOND)
                begin
                    victim_next = first_reg;
                    state_next  = fseen_reg ? S_EVICT : S_FIN;
                end
                else
                begin
                    state_next = cand_reg ? S_EVICT : S_FIN;
                end
            end

            // Read the victim's page and owner.
            S_EVICT:
            begin
                ent_raddr  = victim_reg;
                state_next = S_EVICT2;
            end

            // Evict the victim and move quota on a global steal.
            S_EVICT2:
            begin
                ent_raddr = victim_reg;
                pr_we = 1'b1; pr_wa = victim_reg; pr_wd = 1'b0;
                rf_we = 1'b1; rf_wa = victim_reg; rf_wd = 1'b0;
                lu_we = 1'b1; lu_wa = victim_reg; lu_wd = '0;
                uc_we = 1'b1; uc_wa = victim_reg; uc_wd = '0;
                if (loaded_reg[ow_rd] != '0)
                begin
                    loaded_next[ow_rd] = loaded_reg[ow_rd] - 1'b1;
                end
                if (!local_reg)
                begin
                    if (quota_reg[ow_rd] != '0)
                    begin
                        quota_next[ow_rd] = quota_reg[ow_rd] - 1'b1;
                    end
                    if (quota_next[p_reg] != QUOTA_MAX)
                    begin
                        quota_next[p_reg] = quota_next[p_reg] + 1'b1;
                    end
                end
                res_next.ev_valid = 1'b1;
                res_next.ev_proc  = PID_W'(ow_rd);
                res_next.ev_page  = pg_rd;
                state_next        = S_LOAD;
            end

            // Load the page, mapping and queueing a new one.
            S_LOAD:
            begin
                if (!found_reg)
                begin
                    e_next = base_e + EW'(mapped_reg[p_reg]);
                    mapped_next[p_reg] = mapped_reg[p_reg] + 1'b1;
                    pg_we = 1'b1; pg_wa = e_next;
                    ow_we = 1'b1; ow_wa = e_next;
                    if (qlen_reg < QW'(NE))
                    begin
                        qu_we     = 1'b1;
                        qu_wd     = e_next;
                        qlen_next = qlen_reg + 1'b1;
                    end
                end
                pr_we = 1'b1; pr_wa = e_next; pr_wd = 1'b1;
                rf_we = 1'b1; rf_wa = e_next; rf_wd = 1'b1;
                lu_we = 1'b1; lu_wa = e_next;
                uc_we = 1'b1; uc_wa = e_next; uc_wd = CNT_W'(1);
                loaded_next[p_reg] = loaded_reg[p_reg] + 1'b1;
                state_next = S_FIN;
            end

            // Close the access: time, reference clear period.
            S_FIN:
            begin
                res_next.faults = faults_reg[p_reg];
                time_next       = time_reg + 1'b1;
                sweep_next      = 1'b0;
                if (period_reg != '0)
                begin
                    if (ccount_inc >= {1'b0, period_reg})
                    begin
                        ccount_next = '0;
                        sweep_next  = 1'b1;
                    end
                    else
                    begin
                        ccount_next = PERIOD_W'(ccount_inc);
                    end
                end
                state_next = S_DONE;
            end

            // Hand the result to the output register.
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    idx_next       = '0;
                    state_next     = sweep_reg ? S_RCLR : S_IDLE;
                end
            end

            // Clear every reference bit, one entry per cycle.
            S_RCLR:
            begin
                rf_we = 1'b1;
                rf_wa = EW'(idx_reg);
                rf_wd = 1'b0;
                if (idx_reg == QW'(NE - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Configuration writes; sizing changes restart the clear.
        if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_POLICY: policy_next = policy_t'(cfg_data[1:0]);
                REG_LOCAL:  local_next  = cfg_data[0];
                REG_PCOUNT:
                begin
                    pcount_next = cfg_data[PCOUNT_W-1:0];
                    state_next  = S_CLR;
                    idx_next    = '0;
                    div_go_next = 1'b1;
                end
                REG_FRAMES:
                begin
                    frames_next = cfg_data[FRAMES_W-1:0];
                    state_next  = S_CLR;
                    idx_next    = '0;
                    div_go_next = 1'b1;
                end
                REG_PERIOD: period_next = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // State register and control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            policy_reg    <= POL_FIFO;
            local_reg     <= 1'b0;
            pcount_reg    <= PCOUNT_RST;
            frames_reg    <= FRAMES_RST;
            period_reg    <= PERIOD_RST;
            p_reg         <= '0;
            addr_reg      <= '0;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            e_reg         <= '0;
            qe_reg        <= '0;
            cand_reg      <= 1'b0;
            victim_reg    <= '0;
            best_reg      <= '0;
            fseen_reg     <= 1'b0;
            first_reg     <= '0;
            sweep_reg     <= 1'b0;
            qlen_reg      <= '0;
            time_reg      <= '0;
            ccount_reg    <= '0;
            div_go_reg    <= 1'b1;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_PROCS; i++)
            begin
                mapped_reg[i] <= '0;
                loaded_reg[i] <= '0;
                quota_reg[i]  <= '0;
                faults_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            policy_reg    <= policy_next;
            local_reg     <= local_next;
            pcount_reg    <= pcount_next;
            frames_reg    <= frames_next;
            period_reg    <= period_next;
            p_reg         <= p_next;
            addr_reg      <= addr_next;
            idx_reg       <= idx_next;
            found_reg     <= found_next;
            e_reg         <= e_next;
            qe_reg        <= qe_next;
            cand_reg      <= cand_next;
            victim_reg    <= victim_next;
            best_reg      <= best_next;
            fseen_reg     <= fseen_next;
            first_reg     <= first_next;
            sweep_reg     <= sweep_next;
            qlen_reg      <= qlen_next;
            time_reg      <= time_next;
            ccount_reg    <= ccount_next;
            div_go_reg    <= div_go_next;
            out_valid_reg <= out_valid_next;
            mapped_reg    <= mapped_next;
            loaded_reg    <= loaded_next;
            quota_reg     <= quota_next;
            faults_reg    <= faults_next;
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        out_reg <= out_next;
    end

    // Ports.
    assign cfg_ready       = 1'b1;
    assign in_stall        = (state_reg != S_IDLE);
    assign out_valid       = out_valid_reg;
    assign hit             = out_reg.hit;
    assign fault           = out_reg.fault;
    assign evicted_valid   = out_reg.ev_valid;
    assign evicted_process = out_reg.ev_proc;
    assign evicted_page    = out_reg.ev_page;
    assign table_full      = out_reg.table_full;
    assign process_faults  = out_reg.faults;

endmodule

// ===== rtl/pgr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page replacement tracker checker
// Port-level assertions on the tracker's handshakes and result fields.
// ----------------------------------------------------------------------------
module pgr_props (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic hit,
    input logic fault,
    input logic evicted_valid,
    input logic table_full
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result withdrawn while stalled");

    // After a transfer in, the block is busy with that access.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after a transfer");

    // A hit neither faults nor evicts.
    a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> !fault && !evicted_valid && !table_full)
        else $error("hit result carries fault information");

    // An eviction only comes with a fault on a table that had room.
    a_evict_fault: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && evicted_valid |-> fault && !table_full)
        else $error("eviction without a fault");

endmodule

bind page_replacement_tracker pgr_props u_pgr_props (.*);

// ===== sim/pgr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page replacement tracker checker
// Watches the configuration, access and result channels of the tracker. It
// keeps its own page table, load-order queue and quotas, works out the result
// of every accepted access and compares each result transfer field by field
// with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module pgr_checker
    import pgr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [PID_W-1:0]      process_id,
    input  logic [PAGE_W-1:0]     page_address,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic                  hit,
    input  logic                  fault,
    input  logic                  evicted_valid,
    input  logic [PID_W-1:0]      evicted_process,
    input  logic [PAGE_W-1:0]     evicted_page,
    input  logic                  table_full,
    input  logic [CNT_W-1:0]      process_faults,
    output int                    pending,
    output int                    errors
);

    localparam int NPROC   = MAX_PROCS_DEF;
    localparam int NPAGE   = PAGES_PER_PROC_DEF;
    localparam int NENTRY  = NPROC * NPAGE;

    // Shadow page table.
    logic [PAGE_W-1:0] pg_addr  [NENTRY];
    bit                resident [NENTRY];
    bit                refd     [NENTRY];
    logic [CNT_W-1:0]  last_use [NENTRY];
    logic [CNT_W-1:0]  use_cnt  [NENTRY];
    int                load_q   [NENTRY];
    int                load_len;
    int                mapped   [NPROC];
    int                loaded   [NPROC];
    int                quota    [NPROC];
    int unsigned       faults   [NPROC];
    logic [CNT_W-1:0]  now;
    int                since_clear;

    // Shadow registers.
    policy_t             policy;
    bit                  local_md;
    logic [PCOUNT_W-1:0] pcount;
    logic [FRAMES_W-1:0] frames;
    logic [PERIOD_W-1:0] period;

    result_t expected_results[$];

    function automatic int active_procs();
        int n;
        n = pcount;
        if (n == 0) n = 1;
        if (n > NPROC) n = NPROC;
        return n;
    endfunction

    // Return every table to its reset contents and share out the frames.
    function automatic void wipe_tables();
        int n;
        int share;
        n = active_procs();
        share = frames / n;
        for (int i = 0; i < NENTRY; i++)
        begin
            pg_addr[i]  = '0;
            resident[i] = 0;
            refd[i]     = 0;
            last_use[i] = '0;
            use_cnt[i]  = '0;
            load_q[i]   = 0;
        end
        for (int i = 0; i < NPROC; i++)
        begin
            mapped[i] = 0;
            loaded[i] = 0;
            faults[i] = 0;
            quota[i]  = (i >= n) ? 0 : (i + 1 < n) ? share : frames - share * (n - 1);
        end
        load_len    = 0;
        now         = '0;
        since_clear = 0;
    endfunction

    function automatic bit can_evict(int e, int p, bit loc);
        if (e >= NENTRY || !resident[e]) return 0;
        return !loc || (e / NPAGE == p);
    endfunction

    function automatic int oldest_loaded(int p, bit loc);
        for (int i = 0; i < load_len; i++)
            if (can_evict(load_q[i], p, loc)) return load_q[i];
        return -1;
    endfunction

    function automatic int pick_victim(int p, bit loc);
        int e;
        int cand;
        logic [CNT_W-1:0] key;
        logic [CNT_W-1:0] best;
        cand = -1;
        best = '0;
        case (policy)
            POL_FIFO:
                return oldest_loaded(p, loc);
            POL_SECOND:
            begin
                for (int i = 0; i < load_len; i++)
                begin
                    e = load_q[i];
                    if (!can_evict(e, p, loc)) continue;
                    if (!refd[e]) return e;
                    refd[e] = 0;
                end
                return oldest_loaded(p, loc);
            end
            default:
            begin
                if (!loc)
                begin
                    // Global: the last queue entry holding the minimum wins.
                    for (int i = 0; i < load_len; i++)
                    begin
                        e = load_q[i];
                        if (!can_evict(e, p, 0)) continue;
                        key = (policy == POL_LRU) ? last_use[e] : use_cnt[e];
                        if (cand < 0 || key <= best)
                        begin
                            best = key;
                            cand = e;
                        end
                    end
                end
                else
                begin
                    // Local: the first slot holding the minimum wins.
                    for (int i = 0; i < mapped[p] && i < NPAGE; i++)
                    begin
                        e = p * NPAGE + i;
                        if (!resident[e]) continue;
                        key = (policy == POL_LRU) ? last_use[e] : use_cnt[e];
                        if (cand < 0 || key < best)
                        begin
                            best = key;
                            cand = e;
                        end
                    end
                end
                return cand;
            end
        endcase
    endfunction

    // Apply one access to the shadow state and return its result.
    function automatic result_t predict_access(int p, logic [PAGE_W-1:0] a);
        result_t r;
        int slot;
        int e;
        int v;
        int owner;
        bit found;
        bit ok;
        r = '0;
        slot = 0;
        found = 0;
        ok = 1;
        if (p >= active_procs()) return r;

        for (int i = 0; i < mapped[p] && i < NPAGE; i++)
        begin
            if (pg_addr[p * NPAGE + i] == a)
            begin
                found = 1;
                slot = i;
                break;
            end
        end
        e = p * NPAGE + slot;

        if (found && resident[e])
        begin
            r.hit = 1;
            refd[e] = 1;
            last_use[e] = now;
            if (use_cnt[e] != CNT_MAX) use_cnt[e] = use_cnt[e] + 1;
        end
        else
        begin
            r.fault = 1;
            if (faults[p] < CNT_MAX) faults[p]++;
            if (!found && mapped[p] >= NPAGE)
                r.table_full = 1;
            else
            begin
                if (loaded[p] >= quota[p])
                begin
                    v = pick_victim(p, local_md);
                    if (v < 0)
                        ok = 0;
                    else
                    begin
                        owner = v / NPAGE;
                        resident[v] = 0;
                        refd[v] = 0;
                        use_cnt[v] = '0;
                        last_use[v] = '0;
                        if (loaded[owner] > 0) loaded[owner]--;
                        if (!local_md)
                        begin
                            if (quota[owner] > 0) quota[owner]--;
                            if (quota[p] < QUOTA_MAX) quota[p]++;
                        end
                        r.ev_valid = 1;
                        r.ev_proc  = owner[PID_W-1:0];
                        r.ev_page  = pg_addr[v];
                    end
                end
                if (ok)
                begin
                    if (!found)
                    begin
                        slot = mapped[p];
                        mapped[p]++;
                        e = p * NPAGE + slot;
                        pg_addr[e] = a;
                        if (load_len < NENTRY)
                        begin
                            load_q[load_len] = e;
                            load_len++;
                        end
                    end
                    resident[e] = 1;
                    refd[e] = 1;
                    use_cnt[e] = 1;
                    last_use[e] = now;
                    loaded[p]++;
                end
            end
        end
        r.faults = faults[p][CNT_W-1:0];

        now = now + 1;
        if (period != 0)
        begin
            since_clear++;
            if (since_clear >= period)
            begin
                since_clear = 0;
                for (int i = 0; i < NENTRY; i++) refd[i] = 0;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [CNT_W-1:0] got,
                                   input logic [CNT_W-1:0] want);
        if (errors < 50)
            $display("ERROR at %0t: %s is %0h, predicted %0h", $time, what, got, want);
        errors++;
    endtask

    // Track register writes, accesses and results at each clock edge.
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            policy   = POL_FIFO;
            local_md = 0;
            pcount   = PCOUNT_RST;
            frames   = FRAMES_RST;
            period   = PERIOD_RST;
            wipe_tables();
            expected_results.delete();
            pending = 0;
            errors  = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_POLICY: policy = policy_t'(cfg_data[1:0]);
                    REG_LOCAL:  local_md = cfg_data[0];
                    REG_PCOUNT:
                    begin
                        pcount = cfg_data[PCOUNT_W-1:0];
                        wipe_tables();
                    end
                    REG_FRAMES:
                    begin
                        frames = cfg_data[FRAMES_W-1:0];
                        wipe_tables();
                    end
                    REG_PERIOD: period = cfg_data;
                    default: ;
                endcase
            end

            if (in_valid && !in_stall)
                expected_results.push_back(predict_access(int'(process_id), page_address));

            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result", '0, '0);
                else
                begin
                    want = expected_results.pop_front();
                    if (hit != want.hit) report_mismatch("hit", hit, want.hit);
                    if (fault != want.fault) report_mismatch("fault", fault, want.fault);
                    if (evicted_valid != want.ev_valid)
                        report_mismatch("evicted_valid", evicted_valid, want.ev_valid);
                    if (evicted_process != want.ev_proc)
                        report_mismatch("evicted_process", evicted_process, want.ev_proc);
                    if (evicted_page != want.ev_page)
                        report_mismatch("evicted_page", evicted_page, want.ev_page);
                    if (table_full != want.table_full)
                        report_mismatch("table_full", table_full, want.table_full);
                    if (process_faults != want.faults)
                        report_mismatch("process_faults", process_faults, want.faults);
                end
            end
            pending = expected_results.size();
        end
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page replacement tracker testbench
// Drives directed and random page accesses through a series of replacement
// settings, with random gaps and output stalls, while the checker predicts
// and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
    import pgr_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd5;
    localparam int IDLE_LIMIT = 20000;

    typedef struct {
        policy_t             pol;
        bit                  loc;
        logic [PCOUNT_W-1:0] procs;
        logic [FRAMES_W-1:0] nframes;
        logic [PERIOD_W-1:0] clr;
        int                  pool;
        int                  count;
    } setting_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [PID_W-1:0]      process_id = '0;
    logic [PAGE_W-1:0]     page_address = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  hit, fault, evicted_valid, table_full;
    logic [PID_W-1:0]      evicted_process;
    logic [PAGE_W-1:0]     evicted_page;
    logic [CNT_W-1:0]      process_faults;
    int                    pending;
    int                    errors;
    int                    idle_cycles = 0;
    int                    stall_left = 0;
    bit                    sink_eager = 0;
    bit                    send_eager = 0;

    page_replacement_tracker u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .process_id(process_id), .page_address(page_address),
        .out_valid(out_valid), .out_stall(out_stall),
        .hit(hit), .fault(fault), .evicted_valid(evicted_valid),
        .evicted_process(evicted_process), .evicted_page(evicted_page),
        .table_full(table_full), .process_faults(process_faults)
    );

    pgr_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .process_id(process_id), .page_address(page_address),
        .out_valid(out_valid), .out_stall(out_stall),
        .hit(hit), .fault(fault), .evicted_valid(evicted_valid),
        .evicted_process(evicted_process), .evicted_page(evicted_page),
        .table_full(table_full), .process_faults(process_faults),
        .pending(pending), .errors(errors)
    );

    always #2 clk = ~clk;

    // Result side: after each transfer, stall for a drawn number of cycles.
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            stall_left = sink_eager ? 0 : $urandom_range(0, 15);
            out_stall <= (stall_left != 0);
        end
        else if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            out_stall <= (stall_left != 0);
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // One register write, after which the channel is left quiet before returning.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Stop offering accesses and wait for every outstanding result.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // One access transfer, after a drawn gap unless sending back to back.
    task automatic send_access(input logic [PID_W-1:0] p, input logic [PAGE_W-1:0] a);
        int gap;
        gap = send_eager ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        process_id   <= p;
        page_address <= a;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic apply_setting(input setting_t s);
        wait_drained();
        write_reg(REG_PCOUNT, {12'hFA0, s.procs});
        write_reg(REG_FRAMES, {6'h2B, s.nframes});
        write_reg(REG_POLICY, {14'h3FFF ^ 14'h1555, s.pol});
        write_reg(REG_LOCAL, {15'h7FFF, s.loc});
        write_reg(REG_PERIOD, s.clr);
    endtask

    // Random accesses over a small pool of pages, with some wild addresses.
    task automatic run_random(input setting_t s);
        logic [PAGE_W-1:0] base;
        logic [PAGE_W-1:0] a;
        logic [PID_W-1:0]  p;
        base = PAGE_W'($urandom);
        for (int i = 0; i < s.count; i++)
        begin
            if (i % 20 == 0)
            begin
                send_eager = ($urandom_range(0, 3) == 0);
                sink_eager = ($urandom_range(0, 3) == 0);
            end
            p = PID_W'($urandom_range(0, 7));
            if ($urandom_range(0, 7) == 0)
                a = PAGE_W'($urandom);
            else
                a = base + PAGE_W'($urandom_range(0, s.pool - 1));
            send_access(p, a);
        end
    endtask

    setting_t plan [13];

    initial
    begin
        setting_t s;
        plan[0]  = '{POL_SECOND, 0, 4'd2,  10'd8,    16'd3,     12, 80};
        plan[1]  = '{POL_LRU,    0, 4'd4,  10'd16,   16'd50,    24, 80};
        plan[2]  = '{POL_LFU,    0, 4'd3,  10'd10,   16'hFFFF,  20, 80};
        plan[3]  = '{POL_LRU,    1, 4'd4,  10'd20,   16'd7,     16, 80};
        plan[4]  = '{POL_LFU,    1, 4'd2,  10'd9,    16'd1,     20, 80};
        plan[5]  = '{POL_SECOND, 1, 4'd8,  10'd24,   16'd0,     10, 80};
        plan[6]  = '{POL_FIFO,   1, 4'd8,  10'd1,    16'd5,     4,  60};
        plan[7]  = '{POL_FIFO,   0, 4'd15, 10'd512,  16'd20,    80, 90};
        plan[8]  = '{POL_LRU,    0, 4'd0,  10'd1023, 16'd100,   75, 90};
        plan[9]  = '{POL_FIFO,   0, 4'd1,  10'd1,    16'd2,     6,  50};
        plan[10] = '{POL_SECOND, 0, 4'd3,  10'd0,    16'd4,     8,  40};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: default settings, hits, extreme pages, inactive processes
        // and FIFO evictions once the sixteen frames are used up.
        send_eager = 1;
        send_access(3'd0, 16'h0000);
        send_access(3'd0, 16'h0000);
        send_access(3'd0, 16'hFFFF);
        send_access(3'd0, 16'hAAAA);
        send_access(3'd0, 16'h5555);
        send_access(3'd7, 16'h1234);
        send_access(3'd1, 16'hFFFF);
        for (int i = 1; i <= 14; i++)
            send_access(3'd0, PAGE_W'(i));
        send_access(3'd0, 16'h0000);
        send_access(3'd0, 16'hFFFF);
        send_access(3'd0, 16'h0003);
        send_eager = 0;

        // A write to an index past the register list changes nothing.
        wait_drained();
        write_reg(REG_SPARE, 16'hFFFF);
        write_reg(REG_UNUSED, 16'h0001);
        send_access(3'd0, 16'h0007);

        foreach (plan[k])
        begin
            if (k < 11)
            begin
                apply_setting(plan[k]);
                run_random(plan[k]);
            end
        end

        // Two fully random settings.
        for (int k = 0; k < 2; k++)
        begin
            s.pol     = policy_t'($urandom_range(0, 3));
            s.loc     = 1'($urandom_range(0, 1));
            s.procs   = PCOUNT_W'($urandom_range(1, 8));
            s.nframes = FRAMES_W'($urandom_range(1, 64));
            s.clr     = PERIOD_W'($urandom_range(1, 30));
            s.pool    = $urandom_range(4, 40);
            s.count   = 60;
            apply_setting(s);
            run_random(s);
        end

        wait_drained();
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
